// ===== hdl/jfhs_pkg.sv =====
`default_nettype none

package jfhs_pkg;

    // Parse phase codes, one per byte position in the header walk.
    localparam logic [3:0] PH_SOI0   = 4'd0;
    localparam logic [3:0] PH_SOI1   = 4'd1;
    localparam logic [3:0] PH_PREFIX = 4'd2;
    localparam logic [3:0] PH_MARKER = 4'd3;
    localparam logic [3:0] PH_LENHI  = 4'd4;
    localparam logic [3:0] PH_LENLO  = 4'd5;
    localparam logic [3:0] PH_PREC   = 4'd6;
    localparam logic [3:0] PH_HHI    = 4'd7;
    localparam logic [3:0] PH_HLO    = 4'd8;
    localparam logic [3:0] PH_WHI    = 4'd9;
    localparam logic [3:0] PH_WLO    = 4'd10;
    localparam logic [3:0] PH_COMP   = 4'd11;
    localparam logic [3:0] PH_SKIP   = 4'd12;
    localparam logic [3:0] PH_STOP   = 4'd13;

    // Marker and start-of-image byte values.
    localparam logic [7:0] BYTE_PREFIX   = 8'hFF;
    localparam logic [7:0] BYTE_SOI      = 8'hD8;
    localparam logic [7:0] MARKER_SOF0   = 8'hC0;
    localparam logic [7:0] MARKER_SOF2   = 8'hC2;
    localparam logic [15:0] LEN_FIELD_SZ = 16'd2;

    // Component counts and the format codes they map to.
    localparam logic [7:0] COMP_GREY = 8'd1;
    localparam logic [7:0] COMP_RGB  = 8'd3;
    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_GREY8   = 2'd1;
    localparam logic [1:0] FMT_RGB8    = 2'd2;

    typedef struct packed {
        logic        found;
        logic [15:0] height;
        logic [15:0] width;
        logic [1:0]  fmt;
    } t_result;

    typedef struct packed {
        logic [3:0] phase;
        logic       reported;
    } t_status;

    // Map the component count onto the output format code.
    function automatic logic [1:0] f_pixel_format(input logic [7:0] comps);
        logic [1:0] fmt;
        if (comps == COMP_RGB) begin
            fmt = FMT_RGB8;
        end else if (comps == COMP_GREY) begin
            fmt = FMT_GREY8;
        end else begin
            fmt = FMT_UNKNOWN;
        end
        return fmt;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/jfhs_in_stage.sv =====
`default_nettype none

module jfhs_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_file,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_data_byte,
    output logic            o_end_of_file
);
    import jfhs_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_eof;
    logic       w_accept;

    // The register may be refilled in the same cycle its word moves on.
    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset; it is only read while the valid flag is set.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_data_byte;
            r_eof  <= i_end_of_file;
        end
    end

    assign o_valid       = r_valid;
    assign o_data_byte   = r_byte;
    assign o_end_of_file = r_eof;

endmodule

`default_nettype wire

// ===== hdl/jfhs_parser.sv =====
`default_nettype none

module jfhs_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_file,
    output logic            o_has_result,
    output jfhs_pkg::t_result o_result,
    output jfhs_pkg::t_status o_status
);
    import jfhs_pkg::*;

    logic [3:0]  r_phase;
    logic [3:0]  n_phase;
    logic [15:0] r_skip;
    logic [15:0] n_skip;
    logic [7:0]  r_length_high;
    logic [7:0]  n_length_high;
    logic [7:0]  r_marker;
    logic [7:0]  n_marker;
    logic [15:0] r_height;
    logic [15:0] n_height;
    logic [15:0] r_width;
    logic [15:0] n_width;
    logic        r_reported;
    logic        n_reported;
    logic [15:0] w_seg_len;
    logic [15:0] w_skip_dec;
    logic        w_has;
    t_result     w_res;

    assign w_seg_len  = {r_length_high, i_data_byte} - LEN_FIELD_SZ;
    assign w_skip_dec = r_skip - 16'd1;

    // One phase step per word, plus the end-of-stream restart.
    always_comb begin
        n_phase       = r_phase;
        n_skip        = r_skip;
        n_length_high = r_length_high;
        n_marker      = r_marker;
        n_height      = r_height;
        n_width       = r_width;
        n_reported    = r_reported;
        w_has         = 1'b0;
        w_res         = '0;

        case (r_phase)
            PH_SOI0: begin
                n_phase = (i_data_byte == BYTE_PREFIX) ? PH_SOI1 : PH_STOP;
            end
            PH_SOI1: begin
                n_phase = (i_data_byte == BYTE_SOI) ? PH_PREFIX : PH_STOP;
            end
            PH_PREFIX: begin
                n_phase = PH_MARKER;
            end
            PH_MARKER: begin
                n_marker = i_data_byte;
                n_phase  = PH_LENHI;
            end
            PH_LENHI: begin
                n_length_high = i_data_byte;
                n_phase       = PH_LENLO;
            end
            PH_LENLO: begin
                n_skip = w_seg_len;
                if (r_marker == MARKER_SOF0 || r_marker == MARKER_SOF2) begin
                    n_phase = PH_PREC;
                end else if (w_seg_len == 16'd0) begin
                    n_phase = PH_PREFIX;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_PREC: begin
                n_phase = PH_HHI;
            end
            PH_HHI: begin
                n_height = {i_data_byte, 8'd0};
                n_phase  = PH_HLO;
            end
            PH_HLO: begin
                n_height = {r_height[15:8], i_data_byte};
                n_phase  = PH_WHI;
            end
            PH_WHI: begin
                n_width = {i_data_byte, 8'd0};
                n_phase = PH_WLO;
            end
            PH_WLO: begin
                n_width = {r_width[15:8], i_data_byte};
                n_phase = PH_COMP;
            end
            PH_COMP: begin
                if (!r_reported) begin
                    w_has        = 1'b1;
                    w_res.found  = 1'b1;
                    w_res.height = r_height;
                    w_res.width  = r_width;
                    w_res.fmt    = f_pixel_format(i_data_byte);
                    n_reported   = 1'b1;
                end
                n_phase = PH_STOP;
            end
            PH_SKIP: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == 16'd0) begin
                    n_phase = PH_PREFIX;
                end
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase

        // The last word of a stream reports not-found if nothing was given,
        // and every register returns to its reset value.
        if (i_end_of_file) begin
            if (!r_reported && !w_has) begin
                w_has = 1'b1;
                w_res = '0;
            end
            n_phase       = PH_SOI0;
            n_skip        = '0;
            n_length_high = '0;
            n_marker      = '0;
            n_height      = '0;
            n_width       = '0;
            n_reported    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SOI0;
            r_skip        <= '0;
            r_length_high <= '0;
            r_marker      <= '0;
            r_height      <= '0;
            r_width       <= '0;
            r_reported    <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_skip        <= n_skip;
            r_length_high <= n_length_high;
            r_marker      <= n_marker;
            r_height      <= n_height;
            r_width       <= n_width;
            r_reported    <= n_reported;
        end
    end

    assign o_has_result      = w_has;
    assign o_result          = w_res;
    assign o_status.phase    = r_phase;
    assign o_status.reported = r_reported;

endmodule

`default_nettype wire

// ===== hdl/jfhs_out_stage.sv =====
`default_nettype none

module jfhs_out_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  jfhs_pkg::t_result i_result,
    output logic       o_can_take,
    output logic       o_valid,
    input  wire logic  i_ready,
    output jfhs_pkg::t_result o_result
);
    import jfhs_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // A new result may land in the cycle the held one is taken.
    assign o_can_take = !r_valid || i_ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== hdl/jpeg_frame_header_scanner.sv =====
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+----------------------------------------
// input    | in        | i_in_valid / o_in_ready    | i_data_byte, i_end_of_file
// result   | out       | o_out_valid / i_out_ready  | o_found, o_image_height,
//          |           |                            | o_image_width, o_pixel_format
//
// One byte is accepted per clock cycle unless a stalled result backs up the input; a
// result caused by a byte passes the input register, then the result register.
// The phase step and the 16-bit skip counter decrement between those two
// registers form the combinational work done on each byte.
// Reset is synchronous and active low and returns the parser to awaiting FF.
// A stalled result holds the result register and, through it, the input register;
// bytes keep flowing while it is free or being taken in the same cycle.
`default_nettype none

module jpeg_frame_header_scanner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [15:0]      o_image_height,
    output logic [15:0]      o_image_width,
    output logic [1:0]       o_pixel_format
);
    import jfhs_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_in_eof;
    logic       w_step;
    logic       w_can_take;
    logic       w_has_result;
    t_result    w_step_result;
    t_result    w_out_result;
    t_status    w_status;

    // A byte moves through the parser only when a result could be stored.
    assign w_step = w_in_valid && w_can_take;

    jfhs_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_take        (w_step),
        .o_valid       (w_in_valid),
        .o_data_byte   (w_in_byte),
        .o_end_of_file (w_in_eof)
    );

    jfhs_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_data_byte   (w_in_byte),
        .i_end_of_file (w_in_eof),
        .o_has_result  (w_has_result),
        .o_result      (w_step_result),
        .o_status      (w_status)
    );

    jfhs_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step && w_has_result),
        .i_result   (w_step_result),
        .o_can_take (w_can_take),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (w_out_result)
    );

    assign o_found        = w_out_result.found;
    assign o_image_height = w_out_result.height;
    assign o_image_width  = w_out_result.width;
    assign o_pixel_format = w_out_result.fmt;

    // Once a frame header is reported the parse must have stopped.
    a_report_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.reported |-> (w_status.phase == PH_STOP))
        else $error("reported flag set outside the stopped phase");

    // The last word of a stream always restarts the parser.
    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_in_eof) |=> (w_status.phase == PH_SOI0 && !w_status.reported))
        else $error("parser not restarted after end of stream");

    // A not-found result carries all-zero fields.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
        (o_image_height == 16'd0 && o_image_width == 16'd0 &&
         o_pixel_format == FMT_UNKNOWN))
        else $error("not-found result with non-zero fields");

    // A found result mid-stream marks the stream as reported.
    a_found_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_has_result && w_step_result.found && !w_in_eof) |=>
        w_status.reported)
        else $error("frame header given without setting the reported flag");

endmodule

`default_nettype wire

// ===== verif/jpeg_frame_header_scanner_checker.sv =====
`timescale 1ns / 1ps

module jpeg_frame_header_scanner_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_found,
    input  wire logic [15:0] i_image_height,
    input  wire logic [15:0] i_image_width,
    input  wire logic [1:0]  i_pixel_format,
    output int               o_pending,
    output int               o_mismatches
);

    import jfhs_pkg::*;

    // Shadow copy of the header walk.
    logic [3:0]  scan_phase;
    logic [15:0] bytes_to_skip;
    logic [7:0]  len_msb;
    logic [7:0]  seg_marker;
    logic [15:0] lines_hold;
    logic [15:0] samples_hold;
    logic        header_sent;

    // Frame headers predicted but not yet seen on the result channel.
    t_result expected_headers[$];
    t_result seen_word;
    t_result due_word;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
    end

    task automatic clear_scanner();
        scan_phase    = PH_SOI0;
        bytes_to_skip = '0;
        len_msb       = '0;
        seg_marker    = '0;
        lines_hold    = '0;
        samples_hold  = '0;
        header_sent   = 1'b0;
    endtask

    // Advance the walk by one file byte and queue any header it produces.
    task automatic scan_byte(input logic [7:0] b, input logic eof_flag);
        t_result hdr;
        logic    emitted;
        emitted = 1'b0;
        case (scan_phase)
            PH_SOI0: scan_phase = (b == BYTE_PREFIX) ? PH_SOI1 : PH_STOP;
            PH_SOI1: scan_phase = (b == BYTE_SOI) ? PH_PREFIX : PH_STOP;
            PH_PREFIX: scan_phase = PH_MARKER;
            PH_MARKER: begin
                seg_marker = b;
                scan_phase = PH_LENHI;
            end
            PH_LENHI: begin
                len_msb    = b;
                scan_phase = PH_LENLO;
            end
            PH_LENLO: begin
                // The length counts its own two bytes; short lengths wrap.
                bytes_to_skip = {len_msb, b} - LEN_FIELD_SZ;
                if (seg_marker == MARKER_SOF0 || seg_marker == MARKER_SOF2) begin
                    scan_phase = PH_PREC;
                end else if (bytes_to_skip == 16'd0) begin
                    scan_phase = PH_PREFIX;
                end else begin
                    scan_phase = PH_SKIP;
                end
            end
            PH_PREC: scan_phase = PH_HHI;
            PH_HHI: begin
                lines_hold = {b, 8'h00};
                scan_phase = PH_HLO;
            end
            PH_HLO: begin
                lines_hold = {lines_hold[15:8], b};
                scan_phase = PH_WHI;
            end
            PH_WHI: begin
                samples_hold = {b, 8'h00};
                scan_phase   = PH_WLO;
            end
            PH_WLO: begin
                samples_hold = {samples_hold[15:8], b};
                scan_phase   = PH_COMP;
            end
            PH_COMP: begin
                if (!header_sent) begin
                    hdr.found  = 1'b1;
                    hdr.height = lines_hold;
                    hdr.width  = samples_hold;
                    hdr.fmt    = (b == COMP_RGB) ? FMT_RGB8 :
                                 (b == COMP_GREY) ? FMT_GREY8 : FMT_UNKNOWN;
                    expected_headers.push_back(hdr);
                    emitted     = 1'b1;
                    header_sent = 1'b1;
                end
                scan_phase = PH_STOP;
            end
            PH_SKIP: begin
                bytes_to_skip = bytes_to_skip - 16'd1;
                if (bytes_to_skip == 16'd0) begin
                    scan_phase = PH_PREFIX;
                end
            end
            default: scan_phase = PH_STOP;
        endcase

        // The end of the file always closes the stream; without a header a
        // not-found word is due.
        if (eof_flag) begin
            if (!header_sent && !emitted) begin
                hdr = '0;
                hdr.fmt = FMT_UNKNOWN;
                expected_headers.push_back(hdr);
            end
            clear_scanner();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    // Results are compared before the byte of the same edge is scanned, since
    // no byte can produce a word in the cycle in which it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scanner();
            expected_headers.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen_word.found  = i_found;
                seen_word.height = i_image_height;
                seen_word.width  = i_image_width;
                seen_word.fmt    = i_pixel_format;
                if (expected_headers.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0h",
                             $time, seen_word);
                    o_mismatches++;
                end else begin
                    due_word = expected_headers.pop_front();
                    check_field("found", 16'(due_word.found), 16'(seen_word.found));
                    check_field("image_height", due_word.height, seen_word.height);
                    check_field("image_width", due_word.width, seen_word.width);
                    check_field("pixel_format", 16'(due_word.fmt), 16'(seen_word.fmt));
                end
            end
            if (i_in_valid && i_in_ready) begin
                scan_byte(i_data_byte, i_end_of_file);
            end
        end
        o_pending = expected_headers.size();
    end

endmodule

// ===== verif/jpeg_frame_header_scanner_tb.sv =====
`timescale 1ns / 1ps

module jpeg_frame_header_scanner_tb;

    import jfhs_pkg::*;

    localparam int BYTE_TARGET  = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 15;
    localparam int HOLD_CYCLES  = 400;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [7:0]  data_byte     = 8'h00;
    logic        end_of_file   = 1'b0;
    logic        out_ready     = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        found;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [1:0]  pixel_format;
    int          pending;
    int          mismatches;

    int          cycles     = 0;
    int          bytes_sent = 0;
    int          file_count = 0;
    logic        steady     = 1'b0;
    logic [7:0]  file_bytes[$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    jpeg_frame_header_scanner dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_end_of_file  (end_of_file),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_found        (found),
        .o_image_height (image_height),
        .o_image_width  (image_width),
        .o_pixel_format (pixel_format)
    );

    jpeg_frame_header_scanner_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_end_of_file  (end_of_file),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_found        (found),
        .i_image_height (image_height),
        .i_image_width  (image_width),
        .i_pixel_format (pixel_format),
        .o_pending      (pending),
        .o_mismatches   (mismatches)
    );

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Image dimensions lean towards the extremes now and then.
    function automatic logic [15:0] rand_dim();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            return 16'h0000;
        end else if (pick == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offer one word after a random gap and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic eof_flag);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof_flag;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
        bytes_sent += file_bytes.size();
    endtask

    // A file that starts properly, walks a few segments and reaches a frame
    // header, sometimes cut short on the way.
    task automatic build_jpeg_file();
        int          nseg;
        int          pick;
        int          keep;
        logic [7:0]  mark;
        logic [15:0] seg_len;
        logic [15:0] dim;
        file_bytes.delete();
        file_bytes.push_back(BYTE_PREFIX);
        file_bytes.push_back(BYTE_SOI);
        nseg = $urandom_range(0, 3);
        for (int s = 0; s < nseg; s++) begin
            file_bytes.push_back(($urandom_range(0, 3) == 0) ? rand_byte() : BYTE_PREFIX);
            do mark = rand_byte(); while (mark == MARKER_SOF0 || mark == MARKER_SOF2);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                seg_len = 16'($urandom_range(0, 1));
            end else if (pick == 1) begin
                seg_len = 16'($urandom_range(256, 65535));
            end else begin
                seg_len = 16'($urandom_range(2, 9));
            end
            file_bytes.push_back(mark);
            file_bytes.push_back(seg_len[15:8]);
            file_bytes.push_back(seg_len[7:0]);
            // A wrapped or huge length would take ages to skip: end the file
            // part-way through it instead.
            if (seg_len < 16'd2 || seg_len > 16'd255) begin
                repeat ($urandom_range(0, 6)) file_bytes.push_back(rand_byte());
                return;
            end
            repeat (seg_len - 2) file_bytes.push_back(rand_byte());
        end

        // Frame header segment.
        file_bytes.push_back(($urandom_range(0, 7) == 0) ? rand_byte() : BYTE_PREFIX);
        file_bytes.push_back($urandom_range(0, 1) ? MARKER_SOF0 : MARKER_SOF2);
        file_bytes.push_back(rand_byte());
        file_bytes.push_back(rand_byte());
        file_bytes.push_back(rand_byte());
        dim = rand_dim();
        file_bytes.push_back(dim[15:8]);
        file_bytes.push_back(dim[7:0]);
        dim = rand_dim();
        file_bytes.push_back(dim[15:8]);
        file_bytes.push_back(dim[7:0]);
        pick = $urandom_range(0, 4);
        if (pick < 2) begin
            file_bytes.push_back(COMP_GREY);
        end else if (pick < 4) begin
            file_bytes.push_back(COMP_RGB);
        end else begin
            file_bytes.push_back(rand_byte());
        end
        repeat ($urandom_range(0, 3)) file_bytes.push_back(rand_byte());

        if ($urandom_range(0, 7) == 0) begin
            keep = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
    endtask

    // Short runs of random bytes, often with a plausible start.
    task automatic build_noise_file();
        int n;
        file_bytes.delete();
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            if (i == 0 && $urandom_range(0, 1)) begin
                file_bytes.push_back(BYTE_PREFIX);
            end else if (i == 1 && $urandom_range(0, 1)) begin
                file_bytes.push_back(BYTE_SOI);
            end else begin
                file_bytes.push_back(rand_byte());
            end
        end
    endtask

    // Reset, then release.
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random stalls, one calm stretch and one long hold-off
    // that backs the block up into its input.
    initial begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end else if (taken >= 40 && taken < 60) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 8);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // Byte side: directed files, then random ones, then the verdict.
    initial begin
        wait (rst_n === 1'b1);

        // A file that ends on its very first byte.
        file_bytes = '{8'h7F};
        send_file();
        // Wrong second start byte.
        file_bytes = '{BYTE_PREFIX, 8'h12, 8'hAA};
        send_file();
        // File that ends inside the frame header.
        file_bytes = '{BYTE_PREFIX, BYTE_SOI, 8'h00, MARKER_SOF0, 8'h00, 8'h11, 8'h08,
                       8'h01};
        send_file();
        // Empty segment, then a full-size colour frame ending on its count byte.
        file_bytes = '{BYTE_PREFIX, BYTE_SOI, BYTE_PREFIX, 8'hE1, 8'h00, 8'h02,
                       8'h00, MARKER_SOF2, 8'h00, 8'h11, 8'h08, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, COMP_RGB};
        send_file();

        while (bytes_sent < BYTE_TARGET) begin
            file_count++;
            steady = (file_count % 12) < 2;
            if ($urandom_range(0, 9) < 7) begin
                build_jpeg_file();
            end else begin
                build_noise_file();
            end
            send_file();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== jpeg_frame_header_scanner.f =====
hdl/jfhs_pkg.sv
hdl/jfhs_in_stage.sv
hdl/jfhs_parser.sv
hdl/jfhs_out_stage.sv
hdl/jpeg_frame_header_scanner.sv
verif/jpeg_frame_header_scanner_checker.sv
verif/jpeg_frame_header_scanner_tb.sv
